### rtl/rvx_pkg.sv
// Package for the RV32IM execute block: operation codes, multiply/divide
// kinds and the request/result structures shared by the modules.
// No dependencies.
package rvx_pkg;

    localparam int XLEN = 32;

    // Dense operation codes
    localparam logic [5:0] OP_ADDI   = 6'd0;
    localparam logic [5:0] OP_SLTI   = 6'd1;
    localparam logic [5:0] OP_SLTIU  = 6'd2;
    localparam logic [5:0] OP_XORI   = 6'd3;
    localparam logic [5:0] OP_ORI    = 6'd4;
    localparam logic [5:0] OP_ANDI   = 6'd5;
    localparam logic [5:0] OP_SLLI   = 6'd6;
    localparam logic [5:0] OP_SRLI   = 6'd7;
    localparam logic [5:0] OP_SRAI   = 6'd8;
    localparam logic [5:0] OP_ADD    = 6'd9;
    localparam logic [5:0] OP_SUB    = 6'd10;
    localparam logic [5:0] OP_SLL    = 6'd11;
    localparam logic [5:0] OP_SLT    = 6'd12;
    localparam logic [5:0] OP_SLTU   = 6'd13;
    localparam logic [5:0] OP_XOR    = 6'd14;
    localparam logic [5:0] OP_SRL    = 6'd15;
    localparam logic [5:0] OP_SRA    = 6'd16;
    localparam logic [5:0] OP_OR     = 6'd17;
    localparam logic [5:0] OP_AND    = 6'd18;
    localparam logic [5:0] OP_MUL    = 6'd19;
    localparam logic [5:0] OP_MULH   = 6'd20;
    localparam logic [5:0] OP_MULHSU = 6'd21;
    localparam logic [5:0] OP_MULHU  = 6'd22;
    localparam logic [5:0] OP_DIV    = 6'd23;
    localparam logic [5:0] OP_DIVU   = 6'd24;
    localparam logic [5:0] OP_REM    = 6'd25;
    localparam logic [5:0] OP_REMU   = 6'd26;
    localparam logic [5:0] OP_BEQ    = 6'd27;
    localparam logic [5:0] OP_BNE    = 6'd28;
    localparam logic [5:0] OP_BLT    = 6'd29;
    localparam logic [5:0] OP_BGE    = 6'd30;
    localparam logic [5:0] OP_BLTU   = 6'd31;
    localparam logic [5:0] OP_BGEU   = 6'd32;
    localparam logic [5:0] OP_JAL    = 6'd33;
    localparam logic [5:0] OP_JALR   = 6'd34;
    localparam logic [5:0] OP_LUI    = 6'd35;
    localparam logic [5:0] OP_AUIPC  = 6'd36;
    localparam logic [5:0] OP_ECALL  = 6'd37;
    localparam logic [5:0] OP_EBREAK = 6'd38;
    localparam logic [5:0] OP_FENCE  = 6'd39;

    // Multiply/divide kinds, in operation code order from OP_MUL
    localparam logic [2:0] MD_MUL    = 3'd0;
    localparam logic [2:0] MD_MULH   = 3'd1;
    localparam logic [2:0] MD_MULHSU = 3'd2;
    localparam logic [2:0] MD_MULHU  = 3'd3;
    localparam logic [2:0] MD_DIV    = 3'd4;
    localparam logic [2:0] MD_DIVU   = 3'd5;
    localparam logic [2:0] MD_REM    = 3'd6;
    localparam logic [2:0] MD_REMU   = 3'd7;

    typedef struct packed {
        logic       start;
        logic [2:0] kind;
    } md_req_t;

    typedef struct packed {
        logic [XLEN-1:0] write_value;
        logic            wrote_reg;
        logic [XLEN-1:0] next_pc;
        logic            taken;
        logic            env_call;
        logic            breakpoint;
        logic            fault;
    } result_t;

endpackage

### rtl/rvx_issue_if.sv
// Issue channel interface: one decoded instruction request per handshake.
// Depends on rvx_pkg.
interface rvx_issue_if
    import rvx_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [5:0]        operation;
    logic [4:0]        dest_index;
    logic [4:0]        src1_index;
    logic [4:0]        src2_index;
    logic signed [31:0] immediate;
    logic [XLEN-1:0]   pc;

    modport source (output valid, operation, dest_index, src1_index, src2_index,
                    immediate, pc, input ready);
    modport sink   (input valid, operation, dest_index, src1_index, src2_index,
                    immediate, pc, output ready);
endinterface

### rtl/rvx_result_if.sv
// Result channel interface: one execution result per handshake.
// Depends on rvx_pkg.
interface rvx_result_if
    import rvx_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [XLEN-1:0] write_value;
    logic            wrote_reg;
    logic [XLEN-1:0] next_pc;
    logic            taken;
    logic            env_call;
    logic            breakpoint;
    logic            fault;

    modport source (output valid, write_value, wrote_reg, next_pc, taken, env_call,
                    breakpoint, fault, input ready);
    modport sink   (input valid, write_value, wrote_reg, next_pc, taken, env_call,
                    breakpoint, fault, output ready);
endinterface

### rtl/rvx_regfile.sv
// Integer register file: 32 x 32 memory, two registered read ports, one
// write port, per-entry valid bits so unwritten entries read zero. Uses rvx_pkg.
module rvx_regfile
    import rvx_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rd_en,
    input  logic [4:0]      rd_addr_a,
    input  logic [4:0]      rd_addr_b,
    output logic [XLEN-1:0] rd_data_a,
    output logic [XLEN-1:0] rd_data_b,
    input  logic            wr_en,
    input  logic [4:0]      wr_addr,
    input  logic [XLEN-1:0] wr_data
);

    logic [XLEN-1:0] mem [32];
    logic [31:0]     valid_reg;
    logic [XLEN-1:0] data_a_reg;
    logic [XLEN-1:0] data_b_reg;
    logic            hit_a_reg;
    logic            hit_b_reg;

    // Write the storage array and register both read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_a_reg <= mem[rd_addr_a];
            data_b_reg <= mem[rd_addr_b];
        end
    end

    // Track written entries and register read hits; x0 never counts as written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && (wr_addr != 5'd0))
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_a_reg <= valid_reg[rd_addr_a] && (rd_addr_a != 5'd0);
                hit_b_reg <= valid_reg[rd_addr_b] && (rd_addr_b != 5'd0);
            end
        end
    end

    assign rd_data_a = hit_a_reg ? data_a_reg : '0;
    assign rd_data_b = hit_b_reg ? data_b_reg : '0;

endmodule

### rtl/rvx_muldiv.sv
// Bit-serial multiply/divide unit: shift-add multiply and restoring divide,
// one bit per cycle, then a sign fixup step. Uses rvx_pkg.
module rvx_muldiv
    import rvx_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  md_req_t         req,
    input  logic [XLEN-1:0] opa,
    input  logic [XLEN-1:0] opb,
    output logic            done,
    output logic [XLEN-1:0] result
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIX  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [4:0]      cnt_reg;
    logic [2:0]      kind_reg;
    logic [XLEN-1:0] hi_reg, lo_reg, dv_reg, araw_reg, res_reg;
    logic            neg_reg, sa_reg, bz_reg;

    logic            is_div, sgn_a, sgn_b, sa, sb;
    logic [XLEN-1:0] ma, mb;
    logic [XLEN:0]   msum;
    logic [XLEN:0]   rtrial;
    logic [XLEN+1:0] rdiff;
    logic [2*XLEN-1:0] prod, prod_fix;
    logic [XLEN-1:0] quo_fix, rem_fix;

    // Operand signs and magnitudes at start
    always_comb
    begin
        is_div = req.kind[2];
        sgn_a  = (req.kind == MD_MULH) || (req.kind == MD_MULHSU)
                 || (req.kind == MD_DIV) || (req.kind == MD_REM);
        sgn_b  = (req.kind == MD_MULH) || (req.kind == MD_DIV) || (req.kind == MD_REM);
        sa     = sgn_a & opa[XLEN-1];
        sb     = sgn_b & opb[XLEN-1];
        ma     = sa ? (~opa + 1'b1) : opa;
        mb     = sb ? (~opb + 1'b1) : opb;
    end

    // One iteration step of each algorithm and the sign fixups of the results
    always_comb
    begin
        msum   = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, dv_reg} : '0);
        rtrial = {hi_reg, lo_reg[XLEN-1]};
        rdiff  = {1'b0, rtrial} - {2'b00, dv_reg};
        prod   = {hi_reg, lo_reg};
        prod_fix = neg_reg ? (~prod + 1'b1) : prod;
        quo_fix  = neg_reg ? (~lo_reg + 1'b1) : lo_reg;
        rem_fix  = sa_reg ? (~hi_reg + 1'b1) : hi_reg;
    end

    // Sequence start, iterations, fixup
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (req.start) state_next = S_RUN;
            S_RUN:  if (cnt_reg == 5'd31) state_next = S_FIX;
            S_FIX:  state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_RUN)
            begin
                cnt_reg <= cnt_reg + 5'd1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && req.start)
        begin
            kind_reg <= req.kind;
            araw_reg <= opa;
            bz_reg   <= (opb == '0);
            sa_reg   <= sa;
            neg_reg  <= sa ^ sb;
            hi_reg   <= '0;
            lo_reg   <= is_div ? ma : mb;
            dv_reg   <= is_div ? mb : ma;
        end
        else if (state_reg == S_RUN)
        begin
            if (kind_reg[2])
            begin
                if (!rdiff[XLEN+1])
                begin
                    hi_reg <= rdiff[XLEN-1:0];
                    lo_reg <= {lo_reg[XLEN-2:0], 1'b1};
                end
                else
                begin
                    hi_reg <= rtrial[XLEN-1:0];
                    lo_reg <= {lo_reg[XLEN-2:0], 1'b0};
                end
            end
            else
            begin
                hi_reg <= msum[XLEN:1];
                lo_reg <= {msum[0], lo_reg[XLEN-1:1]};
            end
        end
        else if (state_reg == S_FIX)
        begin
            case (kind_reg)
                MD_MUL:              res_reg <= prod_fix[XLEN-1:0];
                MD_MULH, MD_MULHSU,
                MD_MULHU:            res_reg <= prod_fix[2*XLEN-1:XLEN];
                MD_DIV:              res_reg <= bz_reg ? '1 : quo_fix;
                MD_DIVU:             res_reg <= bz_reg ? '1 : lo_reg;
                MD_REM:              res_reg <= bz_reg ? araw_reg : rem_fix;
                default:             res_reg <= bz_reg ? araw_reg : hi_reg;
            endcase
        end
    end

    assign done   = (state_reg == S_DONE);
    assign result = res_reg;

endmodule

### rtl/rv32im_integer_execute.sv
// Top level of the RV32IM execute block: sequencer, ALU and branch logic,
// result register. Uses rvx_pkg, rvx_issue_if, rvx_result_if, rvx_regfile, rvx_muldiv.
//
// Usage:
//   issue  - decoded instruction requests (valid/ready); a request is taken
//            while the sequencer is idle, even if a previous result waits.
//   result - one result per request (valid/ready), held in an output
//            register until taken.
// Sequence:
//   ALU, branch, jump, upper-immediate and system operations: register
//   read, execute, write back; no new request is taken until the previous
//   one has left write back.
//   Multiply and divide: register read, start, 32 one-bit iterations in the
//   bit-serial multiply/divide unit, sign fixup, hand-off and write back;
//   no new request is taken until the previous one has left write back.
// Reset: all register file entries read zero (per-entry valid bits are
//   cleared at once); no clearing pass.
// Stall: when result is not taken, a finished instruction waits in write
//   back and no new request is taken until the output register frees.
module rv32im_integer_execute
    import rvx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    rvx_issue_if.sink    issue,
    rvx_result_if.source result
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_MD   = 2'd2;
    localparam logic [1:0] S_WB   = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [5:0]      op_reg;
    logic [4:0]      rd_reg;
    logic [XLEN-1:0] imm_reg, pc_reg;
    result_t         res_reg, res_next;
    result_t         out_reg;
    logic            out_valid_reg;

    logic            accept, is_md, load_out, md_done;
    logic [XLEN-1:0] ra, rb, opb, pc4, pc_imm, alu_val, jalr_t, md_result;
    md_req_t         md_req;

    assign accept = issue.valid && issue.ready;
    assign issue.ready = (state_reg == S_IDLE);

    rvx_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (issue.src1_index),
        .rd_addr_b (issue.src2_index),
        .rd_data_a (ra),
        .rd_data_b (rb),
        .wr_en     (load_out && res_reg.wrote_reg),
        .wr_addr   (rd_reg),
        .wr_data   (res_reg.write_value)
    );

    assign is_md = (op_reg >= OP_MUL) && (op_reg <= OP_REMU);

    always_comb
    begin
        md_req.start = (state_reg == S_EXEC) && is_md;
        md_req.kind  = 3'(op_reg - OP_MUL);
    end

    rvx_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (md_req),
        .opa    (ra),
        .opb    (rb),
        .done   (md_done),
        .result (md_result)
    );

    // Register-immediate and register-register ALU, pc sums and jump target
    always_comb
    begin
        opb    = (op_reg <= OP_SRAI) ? imm_reg : rb;
        pc4    = pc_reg + 32'd4;
        pc_imm = pc_reg + imm_reg;
        jalr_t = (ra + imm_reg) & ~32'd1;
        case (op_reg)
            OP_ADDI, OP_ADD:   alu_val = ra + opb;
            OP_SUB:            alu_val = ra - opb;
            OP_SLTI, OP_SLT:   alu_val = {31'd0, $signed(ra) < $signed(opb)};
            OP_SLTIU, OP_SLTU: alu_val = {31'd0, ra < opb};
            OP_XORI, OP_XOR:   alu_val = ra ^ opb;
            OP_ORI, OP_OR:     alu_val = ra | opb;
            OP_ANDI, OP_AND:   alu_val = ra & opb;
            OP_SLLI, OP_SLL:   alu_val = ra << opb[4:0];
            OP_SRLI, OP_SRL:   alu_val = ra >> opb[4:0];
            OP_SRAI, OP_SRA:   alu_val = 32'($signed(ra) >>> opb[4:0]);
            default:           alu_val = '0;
        endcase
    end

    // Resolve write, next pc and flags; multiply/divide value arrives later
    always_comb
    begin
        res_next = '0;
        res_next.next_pc = pc4;
        if (op_reg <= OP_REMU)
        begin
            res_next.write_value = alu_val;
            res_next.wrote_reg   = 1'b1;
        end
        else if ((op_reg >= OP_BEQ) && (op_reg <= OP_BGEU))
        begin
            case (op_reg)
                OP_BEQ:  res_next.taken = (ra == rb);
                OP_BNE:  res_next.taken = (ra != rb);
                OP_BLT:  res_next.taken = $signed(ra) < $signed(rb);
                OP_BGE:  res_next.taken = !($signed(ra) < $signed(rb));
                OP_BLTU: res_next.taken = (ra < rb);
                default: res_next.taken = (ra >= rb);
            endcase
            res_next.next_pc = res_next.taken ? pc_imm : pc4;
            res_next.fault   = |res_next.next_pc[1:0];
        end
        else if ((op_reg == OP_JAL) || (op_reg == OP_JALR))
        begin
            if (op_reg == OP_JAL)
            begin
                res_next.next_pc = pc_imm;
            end
            else
            begin
                res_next.next_pc = jalr_t;
            end
            if (|res_next.next_pc[1:0])
            begin
                res_next.fault   = 1'b1;
                res_next.next_pc = pc4;
            end
            else
            begin
                res_next.write_value = pc4;
                res_next.wrote_reg   = 1'b1;
            end
        end
        else if (op_reg == OP_LUI)
        begin
            res_next.write_value = imm_reg;
            res_next.wrote_reg   = 1'b1;
        end
        else if (op_reg == OP_AUIPC)
        begin
            res_next.write_value = pc_imm;
            res_next.wrote_reg   = 1'b1;
        end
        else if (op_reg == OP_ECALL)
        begin
            res_next.env_call = 1'b1;
        end
        else if (op_reg == OP_EBREAK)
        begin
            res_next.breakpoint = 1'b1;
        end
        else if (op_reg != OP_FENCE)
        begin
            res_next.fault = 1'b1;
        end
        // Drop writes to x0
        if (rd_reg == 5'd0)
        begin
            res_next.wrote_reg   = 1'b0;
            res_next.write_value = '0;
        end
    end

    assign load_out = (state_reg == S_WB) && (!out_valid_reg || result.ready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_EXEC;
            S_EXEC: state_next = is_md ? S_MD : S_WB;
            S_MD:   if (md_done) state_next = S_WB;
            S_WB:   if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold request fields, working result and output register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= issue.operation;
            rd_reg  <= issue.dest_index;
            imm_reg <= issue.immediate;
            pc_reg  <= issue.pc;
        end
        if (state_reg == S_EXEC)
        begin
            res_reg <= res_next;
        end
        else if ((state_reg == S_MD) && md_done && (rd_reg != 5'd0))
        begin
            res_reg.write_value <= md_result;
        end
        if (load_out)
        begin
            out_reg <= res_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.write_value = out_reg.write_value;
    assign result.wrote_reg   = out_reg.wrote_reg;
    assign result.next_pc     = out_reg.next_pc;
    assign result.taken       = out_reg.taken;
    assign result.env_call    = out_reg.env_call;
    assign result.breakpoint  = out_reg.breakpoint;
    assign result.fault       = out_reg.fault;

endmodule

### dv/rv32im_integer_execute_tb.sv
// Testbench for the RV32IM execute block: directed and random instruction
// requests checked against a built-in predictor with its own register file.
// Depends on rvx_pkg, rvx_issue_if, rvx_result_if and the block's RTL.
module rv32im_integer_execute_tb;
    import rvx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    int   error_count;
    bit   calm;

    rvx_issue_if  issue ();
    rvx_result_if result ();

    rv32im_integer_execute u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .issue  (issue.sink),
        .result (result.source)
    );

    // Predictor state and store of expected results
    logic [31:0] arch_regs [32];
    result_t     expected_results [$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] read_reg(input logic [4:0] idx);
        return (idx == 5'd0) ? 32'd0 : arch_regs[idx];
    endfunction

    // Compute signed or unsigned quotient / remainder per spec corner rules
    function automatic logic [31:0] divide(input logic [31:0] a, input logic [31:0] b,
                                           input bit sgn, input bit want_rem);
        logic [31:0] ma, mb, q, r;
        if (b == 32'd0)
            return want_rem ? a : 32'hFFFF_FFFF;
        if (!sgn)
            return want_rem ? (a % b) : (a / b);
        if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
            return want_rem ? 32'd0 : 32'h8000_0000;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        r = ma % mb;
        if (a[31] ^ b[31])
            q = -q;
        if (a[31])
            r = -r;
        return want_rem ? r : q;
    endfunction

    // Execute one instruction against the predictor's register file
    function automatic result_t execute(input logic [5:0] op, input logic [4:0] rd,
                                        input logic [4:0] rs1, input logic [4:0] rs2,
                                        input logic [31:0] imm, input logic [31:0] pc);
        result_t     res;
        logic [31:0] a, b, v, tgt;
        logic [63:0] prod;
        bit          wr, tk, flt;
        a = read_reg(rs1);
        b = read_reg(rs2);
        v = 32'd0;
        wr = 1'b1;
        tk = 1'b0;
        flt = 1'b0;
        res = '0;
        res.next_pc = pc + 32'd4;
        case (op)
            OP_ADDI:   v = a + imm;
            OP_SLTI:   v = {31'd0, $signed(a) < $signed(imm)};
            OP_SLTIU:  v = {31'd0, a < imm};
            OP_XORI:   v = a ^ imm;
            OP_ORI:    v = a | imm;
            OP_ANDI:   v = a & imm;
            OP_SLLI:   v = a << imm[4:0];
            OP_SRLI:   v = a >> imm[4:0];
            OP_SRAI:   v = $signed(a) >>> imm[4:0];
            OP_ADD:    v = a + b;
            OP_SUB:    v = a - b;
            OP_SLL:    v = a << b[4:0];
            OP_SLT:    v = {31'd0, $signed(a) < $signed(b)};
            OP_SLTU:   v = {31'd0, a < b};
            OP_XOR:    v = a ^ b;
            OP_SRL:    v = a >> b[4:0];
            OP_SRA:    v = $signed(a) >>> b[4:0];
            OP_OR:     v = a | b;
            OP_AND:    v = a & b;
            OP_MUL:    v = a * b;
            OP_MULH:
            begin
                prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                v = prod[63:32];
            end
            OP_MULHSU:
            begin
                prod = {{32{a[31]}}, a} * {32'd0, b};
                v = prod[63:32];
            end
            OP_MULHU:
            begin
                prod = {32'd0, a} * {32'd0, b};
                v = prod[63:32];
            end
            OP_DIV:    v = divide(a, b, 1'b1, 1'b0);
            OP_DIVU:   v = divide(a, b, 1'b0, 1'b0);
            OP_REM:    v = divide(a, b, 1'b1, 1'b1);
            OP_REMU:   v = divide(a, b, 1'b0, 1'b1);
            OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU:
            begin
                wr = 1'b0;
                case (op)
                    OP_BEQ:  tk = (a == b);
                    OP_BNE:  tk = (a != b);
                    OP_BLT:  tk = $signed(a) < $signed(b);
                    OP_BGE:  tk = $signed(a) >= $signed(b);
                    OP_BLTU: tk = a < b;
                    default: tk = a >= b;
                endcase
                if (tk)
                    res.next_pc = pc + imm;
                flt = (res.next_pc[1:0] != 2'd0);
            end
            OP_JAL, OP_JALR:
            begin
                tgt = (op == OP_JAL) ? pc + imm : ((a + imm) & ~32'd1);
                if (tgt[1:0] != 2'd0)
                begin
                    flt = 1'b1;
                    wr = 1'b0;
                end
                else
                begin
                    v = pc + 32'd4;
                    res.next_pc = tgt;
                end
            end
            OP_LUI:    v = imm;
            OP_AUIPC:  v = pc + imm;
            OP_ECALL:
            begin
                wr = 1'b0;
                res.env_call = 1'b1;
            end
            OP_EBREAK:
            begin
                wr = 1'b0;
                res.breakpoint = 1'b1;
            end
            OP_FENCE:  wr = 1'b0;
            default:
            begin
                wr = 1'b0;
                flt = 1'b1;
            end
        endcase
        if (!wr || rd == 5'd0)
        begin
            wr = 1'b0;
            v = 32'd0;
        end
        else
            arch_regs[rd] = v;
        res.write_value = v;
        res.wrote_reg = wr;
        res.taken = tk;
        res.fault = flt;
        return res;
    endfunction

    // Send one request, sometimes after a random gap (never when calm), and queue its prediction
    task automatic send_request(input logic [5:0] op, input logic [4:0] rd,
                                input logic [4:0] rs1, input logic [4:0] rs2,
                                input logic [31:0] imm, input logic [31:0] pc);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            issue.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        issue.valid      <= 1'b1;
        issue.operation  <= op;
        issue.dest_index <= rd;
        issue.src1_index <= rs1;
        issue.src2_index <= rs2;
        issue.immediate  <= imm;
        issue.pc         <= pc;
        @(posedge clk);
        while (!issue.ready)
            @(posedge clk);
        expected_results.push_back(execute(op, rd, rs1, rs2, imm, pc));
    endtask

    task automatic finish_sending();
        issue.valid <= 1'b0;
    endtask

    function automatic logic [31:0] edge_value();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Random receiver stall bursts
    initial
    begin
        int burst;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 5);
                result.ready <= 1'b0;
                repeat (burst) @(posedge clk);
            end
            else
            begin
                result.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n && result.valid && result.ready)
        begin
            got = '{result.write_value, result.wrote_reg, result.next_pc, result.taken,
                    result.env_call, result.breakpoint, result.fault};
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.write_value !== want.write_value)
                begin
                    $display("%0t: write_value exp %h got %h", $time, want.write_value,
                             got.write_value);
                    error_count++;
                end
                if (got.wrote_reg !== want.wrote_reg)
                begin
                    $display("%0t: wrote_reg exp %b got %b", $time, want.wrote_reg,
                             got.wrote_reg);
                    error_count++;
                end
                if (got.next_pc !== want.next_pc)
                begin
                    $display("%0t: next_pc exp %h got %h", $time, want.next_pc, got.next_pc);
                    error_count++;
                end
                if (got.taken !== want.taken)
                begin
                    $display("%0t: taken exp %b got %b", $time, want.taken, got.taken);
                    error_count++;
                end
                if (got.env_call !== want.env_call)
                begin
                    $display("%0t: env_call exp %b got %b", $time, want.env_call,
                             got.env_call);
                    error_count++;
                end
                if (got.breakpoint !== want.breakpoint)
                begin
                    $display("%0t: breakpoint exp %b got %b", $time, want.breakpoint,
                             got.breakpoint);
                    error_count++;
                end
                if (got.fault !== want.fault)
                begin
                    $display("%0t: fault exp %b got %b", $time, want.fault, got.fault);
                    error_count++;
                end
            end
        end
    end

    // Load extremes into registers, then exercise chosen corner cases
    task automatic test_directed();
        int i;
        send_request(OP_LUI, 5'd1, 5'd0, 5'd0, 32'h8000_0000, 32'd0);
        send_request(OP_ADDI, 5'd2, 5'd0, 5'd0, 32'hFFFF_FFFF, 32'd4);
        send_request(OP_ADDI, 5'd3, 5'd0, 5'd0, 32'h7FFF_FFFF, 32'd8);
        send_request(OP_ADDI, 5'd0, 5'd2, 5'd0, 32'd5, 32'd12);
        send_request(OP_DIV, 5'd4, 5'd1, 5'd2, 32'd0, 32'd16);
        send_request(OP_REM, 5'd5, 5'd1, 5'd2, 32'd0, 32'd20);
        send_request(OP_DIVU, 5'd6, 5'd3, 5'd0, 32'd0, 32'd24);
        send_request(OP_REMU, 5'd7, 5'd3, 5'd0, 32'd0, 32'd28);
        send_request(OP_DIV, 5'd8, 5'd1, 5'd0, 32'd0, 32'd32);
        send_request(OP_REM, 5'd9, 5'd1, 5'd0, 32'd0, 32'd36);
        send_request(OP_SRAI, 5'd10, 5'd1, 5'd0, 32'hFFFF_FFFF, 32'd40);
        send_request(OP_SLL, 5'd11, 5'd2, 5'd2, 32'd0, 32'd44);
        send_request(OP_JALR, 5'd12, 5'd2, 5'd0, 32'd5, 32'd48);
        send_request(OP_JALR, 5'd13, 5'd2, 5'd0, 32'd3, 32'd52);
        send_request(OP_JAL, 5'd14, 5'd0, 5'd0, 32'd2, 32'd56);
        send_request(OP_BEQ, 5'd0, 5'd0, 5'd0, 32'd6, 32'd60);
        send_request(OP_BNE, 5'd0, 5'd0, 5'd0, 32'd8, 32'hFFFF_FFFE);
        send_request(OP_ADD, 5'd15, 5'd15, 5'd15, 32'd0, 32'hFFFF_FFFC);
        send_request(6'd63, 5'd16, 5'd1, 5'd2, 32'd0, 32'd64);
        send_request(OP_MULH, 5'd17, 5'd1, 5'd1, 32'd0, 32'd68);
        for (i = OP_ECALL; i <= OP_FENCE; i++)
            send_request(i[5:0], 5'd18, 5'd1, 5'd2, 32'd0, 32'd72);
    endtask

    // Random instructions over all codes with biased operands
    task automatic test_random(input int count);
        int          i;
        logic [5:0]  op;
        logic [31:0] imm, pc;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // Seed a register with an extreme value
                send_request(OP_LUI, 5'($urandom_range(1, 31)), 5'($urandom()),
                             5'($urandom()), edge_value(), {30'($urandom()), 2'b00});
                continue;
            end
            op = ($urandom_range(0, 15) == 0) ? 6'($urandom_range(40, 63))
                                               : 6'($urandom_range(0, 39));
            imm = ($urandom_range(0, 3) == 0) ? edge_value()
                  : (($urandom_range(0, 1) == 0) ? {22'd0, 8'($urandom_range(0, 255)), 2'b00}
                                                 : $urandom());
            pc = ($urandom_range(0, 7) == 0) ? $urandom() : {30'($urandom()), 2'b00};
            send_request(op, 5'($urandom()), 5'($urandom()), 5'($urandom()), imm, pc);
        end
    endtask

    // Timeout
    initial
    begin
        #20ms;
        $display("[rv32im_integer_execute] ERROR");
        $finish;
    end

    initial
    begin
        int i;
        clk = 1'b0;
        rst_n = 1'b0;
        error_count = 0;
        calm = 1'b0;
        for (i = 0; i < 32; i++)
            arch_regs[i] = 32'd0;
        issue.valid = 1'b0;
        issue.operation = '0;
        issue.dest_index = '0;
        issue.src1_index = '0;
        issue.src2_index = '0;
        issue.immediate = '0;
        issue.pc = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1000);
        calm = 1'b1;
        test_random(230);
        finish_sending();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("[rv32im_integer_execute] OK");
        else
            $display("[rv32im_integer_execute] ERROR");
        $finish;
    end
endmodule

### rv32im_integer_execute.f
rtl/rvx_pkg.sv
rtl/rvx_issue_if.sv
rtl/rvx_result_if.sv
rtl/rvx_regfile.sv
rtl/rvx_muldiv.sv
rtl/rv32im_integer_execute.sv
dv/rv32im_integer_execute_tb.sv
